// ===== rtl/core/hsm_pkg.sv =====
// ----------------------------------------------------------------------------
// hsm_pkg
// Shared types and codes for the hash set membership unit.
// ----------------------------------------------------------------------------
package hsm_pkg;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_ERASE  = 2'd1;
    localparam cmd_t CMD_FIND   = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

endpackage

// ===== rtl/core/hash_set_membership_unit.sv =====
// ----------------------------------------------------------------------------
// hash_set_membership_unit
// Bucketed hash set with insert, erase and find; the spare code acts as find.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries cmd and key; output channel
// out_valid/out_ready carries present and overflow, one result beat per
// input beat, in order.
// The bucket is the low bits of the key. After a beat is accepted a single
// comparator walks the bucket's ways, one way per cycle, stopping at the
// first match. A new beat is not accepted until the way walk over the key
// RAM for the previous one has ended.
// The result is registered; out_valid rises once the walk has ended and the output register is free.
// The table update is written back in the last walk cycle.
// After reset the valid-mark RAM is swept clear, one bucket per cycle,
// over all BUCKETS buckets; in_ready stays low meanwhile.
// If the receiver stalls, a finished result waits in a pending register
// and no new beat is accepted until the output register frees up.
// ----------------------------------------------------------------------------
module hash_set_membership_unit
    import hsm_pkg::*;
#(
    parameter int BUCKETS  = 256,
    parameter int WAYS     = 8,
    parameter int KEY_BITS = 31
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [KEY_BITS-1:0] key,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                present,
    output logic                overflow
);

    localparam int BUCKET_BITS = $clog2(BUCKETS);
    localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS       = BUCKETS * WAYS;
    localparam int ADDR_BITS   = $clog2(SLOTS);

    state_t                 state_reg, state_next;
    logic [BUCKET_BITS-1:0] clr_reg, clr_next;
    logic                   out_valid_reg, out_valid_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [BUCKET_BITS-1:0] bucket_reg, bucket_next;
    logic [WAY_BITS-1:0]    way_reg, way_next;
    logic                   present_reg, present_next;
    logic                   overflow_reg, overflow_next;
    logic                   pend_present_reg, pend_present_next;
    logic                   pend_overflow_reg, pend_overflow_next;

    logic [BUCKET_BITS-1:0] in_bucket;
    logic [ADDR_BITS-1:0]   in_base, base;
    logic                   last_way;
    logic [WAY_BITS-1:0]    scan_way;
    logic [WAY_BITS-1:0]    free_idx;
    logic                   free_any;
    logic                   match;
    logic                   res_present, res_overflow;
    logic                   out_free;

    logic                   v_we;
    logic [BUCKET_BITS-1:0] v_waddr, v_raddr;
    logic [WAYS-1:0]        v_wdata, vrow;
    logic                   k_we;
    logic [ADDR_BITS-1:0]   k_waddr, k_raddr;
    logic [KEY_BITS-1:0]    k_rdata;

    hsm_ram #(
        .WIDTH (WAYS),
        .DEPTH (BUCKETS)
    ) u_valid_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (vrow)
    );

    hsm_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (key_reg),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    hsm_way_cmp #(
        .KEY_BITS (KEY_BITS),
        .WAYS     (WAYS)
    ) u_cmp (
        .vrow       (vrow),
        .way        (way_reg),
        .stored_key (k_rdata),
        .key        (key_reg),
        .match      (match)
    );

    assign in_bucket = BUCKET_BITS'(key);
    assign in_base   = ADDR_BITS'(ADDR_BITS'(in_bucket) * ADDR_BITS'(WAYS));
    assign base      = ADDR_BITS'(ADDR_BITS'(bucket_reg) * ADDR_BITS'(WAYS));
    assign last_way  = (way_reg == WAY_BITS'(WAYS - 1));
    assign scan_way  = last_way ? way_reg : way_reg + WAY_BITS'(1);
    assign out_free  = !out_valid_reg || out_ready;

    // lowest free way of the bucket
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (!vrow[i])
            begin
                free_idx = WAY_BITS'(i);
                free_any = 1'b1;
            end
        end
    end

    assign res_present  = match;
    assign res_overflow = (cmd_reg == CMD_INSERT) && !match && !free_any;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        key_reg           <= key_next;
        bucket_reg        <= bucket_next;
        way_reg           <= way_next;
        present_reg       <= present_next;
        overflow_reg      <= overflow_next;
        pend_present_reg  <= pend_present_next;
        pend_overflow_reg <= pend_overflow_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        clr_next           = clr_reg;
        out_valid_next     = out_valid_reg;
        cmd_next           = cmd_reg;
        key_next           = key_reg;
        bucket_next        = bucket_reg;
        way_next           = way_reg;
        present_next       = present_reg;
        overflow_next      = overflow_reg;
        pend_present_next  = pend_present_reg;
        pend_overflow_next = pend_overflow_reg;

        in_ready = 1'b0;
        v_we     = 1'b0;
        v_waddr  = bucket_reg;
        v_wdata  = vrow;
        v_raddr  = bucket_reg;
        k_we     = 1'b0;
        k_waddr  = base + ADDR_BITS'(free_idx);
        k_raddr  = base + ADDR_BITS'(scan_way);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                v_we     = 1'b1;
                v_waddr  = clr_reg;
                v_wdata  = '0;
                clr_next = clr_reg + BUCKET_BITS'(1);
                if (clr_reg == BUCKET_BITS'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                v_raddr  = in_bucket;
                k_raddr  = in_base;
                if (in_valid)
                begin
                    cmd_next    = cmd;
                    key_next    = key;
                    bucket_next = in_bucket;
                    way_next    = '0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (match || last_way)
                begin
                    if ((cmd_reg == CMD_INSERT) && !match && free_any)
                    begin
                        k_we    = 1'b1;
                        v_we    = 1'b1;
                        v_wdata = vrow | (WAYS'(1) << free_idx);
                    end
                    else if ((cmd_reg == CMD_ERASE) && match)
                    begin
                        v_we    = 1'b1;
                        v_wdata = vrow & ~(WAYS'(1) << way_reg);
                    end
                    pend_present_next  = res_present;
                    pend_overflow_next = res_overflow;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        present_next   = res_present;
                        overflow_next  = res_overflow;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
                else
                begin
                    way_next = scan_way;
                end
            end

            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    present_next   = pend_present_reg;
                    overflow_next  = pend_overflow_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign present   = present_reg;
    assign overflow  = overflow_reg;

endmodule

// ===== rtl/core/hsm_ram.sv =====
// ----------------------------------------------------------------------------
// hsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsm_ram
    import hsm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/hsm_way_cmp.sv =====
// ----------------------------------------------------------------------------
// hsm_way_cmp
// Shared way compare: one stored key against the looked-up key, gated by
// the way's valid mark.
// ----------------------------------------------------------------------------
module hsm_way_cmp
    import hsm_pkg::*;
#(
    parameter int KEY_BITS = 31,
    parameter int WAYS     = 8
)
(
    input  logic [WAYS-1:0]                        vrow,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] way,
    input  logic [KEY_BITS-1:0]                    stored_key,
    input  logic [KEY_BITS-1:0]                    key,
    output logic                                   match
);

    assign match = vrow[way] && (stored_key == key);

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hash_set_membership_unit.
// A directed table covers empty, hit, re-insert, spare opcode, extreme keys and
// a bucket filled past its ways. Random insert/erase/find/spare traffic follows,
// focused on a few hot buckets so hits, misses and overflow all occur. Each
// accepted beat is run through a shadow table; result beats are compared in
// order under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import hsm_pkg::*;

    localparam int BUCKETS      = 256;
    localparam int WAYS         = 8;
    localparam int KEY_BITS     = 31;
    localparam int SLOTS        = BUCKETS * WAYS;
    localparam int RAND_OPS     = 1600;
    localparam int DRAIN_EVERY  = 400;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOT_COUNT    = 16;
    localparam int SEEN_DEPTH   = 64;

    localparam cmd_t CMD_SPARE = 2'd3;

    localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};
    localparam logic [KEY_BITS-1:0] KEY_TOP = {1'b1, {(KEY_BITS-1){1'b0}}};

    typedef struct packed {
        cmd_t                op;
        logic [KEY_BITS-1:0] k;
        logic                typed;
        logic                present;
        logic                overflow;
    } op_row_t;

    typedef struct packed {
        cmd_t                op;
        logic [KEY_BITS-1:0] k;
        logic                present;
        logic                overflow;
    } result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          cmd;
    logic [KEY_BITS-1:0] key;
    logic                out_valid;
    logic                out_ready;
    logic                present;
    logic                overflow;

    logic [KEY_BITS-1:0] shadow_key  [SLOTS];
    logic                shadow_used [SLOTS];

    op_row_t             dir_rows[$];
    result_t             due_results[$];

    logic [KEY_BITS-1:0] seen_keys [SEEN_DEPTH];
    int                  hot_bucket [HOT_COUNT];
    int                  seen_count;
    int                  seen_wr;
    int                  burst_left;
    int                  errors = 0;
    int                  cycles = 0;

    hash_set_membership_unit #(
        .BUCKETS  (BUCKETS),
        .WAYS     (WAYS),
        .KEY_BITS (KEY_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .present   (present),
        .overflow  (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // Lookup in the shadow table, then apply insert/erase; lowest free way wins.
    function automatic void apply_set_op(input cmd_t op, input logic [KEY_BITS-1:0] k,
                                         output logic hit, output logic dropped);
        int base;
        int way;
        int free_way;
        base     = int'(k % BUCKETS) * WAYS;
        way      = -1;
        free_way = -1;
        for (int w = 0; w < WAYS; w++)
        begin
            if (way < 0 && shadow_used[base + w] && shadow_key[base + w] == k)
                way = w;
            if (free_way < 0 && !shadow_used[base + w])
                free_way = w;
        end
        hit     = (way >= 0);
        dropped = 1'b0;
        if (op == CMD_INSERT && way < 0)
        begin
            if (free_way < 0)
                dropped = 1'b1;
            else
            begin
                shadow_key[base + free_way]  = k;
                shadow_used[base + free_way] = 1'b1;
            end
        end
        else if (op == CMD_ERASE && way >= 0)
            shadow_used[base + way] = 1'b0;
    endfunction

    task automatic add_row(input cmd_t op, input logic [KEY_BITS-1:0] k, input logic typed,
                           input logic p, input logic ov);
        op_row_t r;
        r.op       = op;
        r.k        = k;
        r.typed    = typed;
        r.present  = p;
        r.overflow = ov;
        dir_rows = {dir_rows, r};
    endtask

    // Hold the beat until accepted, then queue its result.
    task automatic send_op(input op_row_t r);
        result_t res;
        in_valid <= 1'b1;
        cmd      <= r.op;
        key      <= r.k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res.op = r.op;
        res.k  = r.k;
        apply_set_op(r.op, r.k, res.present, res.overflow);
        if (r.typed)
        begin
            res.present  = r.present;
            res.overflow = r.overflow;
        end
        due_results = {due_results, res};
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: modes of always-ready, random stalls and long stalls.
    initial
    begin
        int mode;
        int mode_left;
        int hold;
        mode      = 0;
        mode_left = 0;
        hold      = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (hold > 0)
                    begin
                        hold--;
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 3) == 0)
                            hold = $urandom_range(1, 12);
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : check_out
        result_t res;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
                report_mismatch($sformatf("result beat with none pending (p=%0b ov=%0b)",
                                          present, overflow));
            else
            begin
                res = due_results.pop_front();
                if (present !== res.present)
                    report_mismatch($sformatf("present got %0b want %0b (cmd %0d key %h)",
                                              present, res.present, res.op, res.k));
                if (overflow !== res.overflow)
                    report_mismatch($sformatf("overflow got %0b want %0b (cmd %0d key %h)",
                                              overflow, res.overflow, res.op, res.k));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        op_row_t             r;
        int                  pick;
        logic [KEY_BITS-1:0] k;

        seen_count = 0;
        seen_wr    = 0;
        burst_left = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= CMD_FIND;
        key       <= '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            shadow_key[s]  = '0;
            shadow_used[s] = 1'b0;
        end

        add_row(CMD_FIND,   '0,      1'b1, 1'b0, 1'b0);
        add_row(CMD_INSERT, '0,      1'b1, 1'b0, 1'b0);
        add_row(CMD_INSERT, '0,      1'b1, 1'b1, 1'b0);
        add_row(CMD_SPARE,  '0,      1'b1, 1'b1, 1'b0);
        add_row(CMD_ERASE,  '0,      1'b1, 1'b1, 1'b0);
        add_row(CMD_ERASE,  '0,      1'b1, 1'b0, 1'b0);
        add_row(CMD_FIND,   '0,      1'b1, 1'b0, 1'b0);
        add_row(CMD_INSERT, KEY_MAX, 1'b1, 1'b0, 1'b0);
        add_row(CMD_FIND,   KEY_MAX, 1'b1, 1'b1, 1'b0);
        add_row(CMD_INSERT, KEY_TOP, 1'b1, 1'b0, 1'b0);
        add_row(CMD_ERASE,  KEY_MAX, 1'b1, 1'b1, 1'b0);
        // fill one bucket, then overflow it
        for (int w = 0; w < WAYS; w++)
            add_row(CMD_INSERT, KEY_BITS'(5 + BUCKETS * w), 1'b1, 1'b0, 1'b0);
        add_row(CMD_INSERT, KEY_BITS'(5 + BUCKETS * WAYS), 1'b1, 1'b0, 1'b1);
        add_row(CMD_FIND,   KEY_BITS'(5 + BUCKETS * WAYS), 1'b1, 1'b0, 1'b0);
        add_row(CMD_ERASE,  KEY_BITS'(5 + BUCKETS * 3),    1'b1, 1'b1, 1'b0);
        add_row(CMD_INSERT, KEY_BITS'(5 + BUCKETS * WAYS), 1'b0, 1'b0, 1'b0);
        add_row(CMD_SPARE,  KEY_BITS'(5 + BUCKETS * 3),    1'b0, 1'b0, 1'b0);
        add_row(CMD_INSERT, KEY_BITS'(5 + BUCKETS * 3),    1'b0, 1'b0, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < dir_rows.size(); i++)
        begin
            send_op(dir_rows[i]);
            if (i == dir_rows.size() - 1)
                drain();
            else
                pace();
        end

        hot_bucket[0] = 0;
        hot_bucket[1] = BUCKETS - 1;
        for (int h = 2; h < HOT_COUNT; h++)
            hot_bucket[h] = $urandom_range(0, BUCKETS - 1);

        for (int i = 0; i < RAND_OPS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                r.op = CMD_INSERT;
            else if (pick < 65)
                r.op = CMD_ERASE;
            else if (pick < 95)
                r.op = CMD_FIND;
            else
                r.op = CMD_SPARE;

            pick = $urandom_range(0, 99);
            if (pick < 45 && seen_count > 0)
                k = seen_keys[$urandom_range(0, seen_count - 1)];
            else if (pick < 90)
            begin
                k = KEY_BITS'($urandom);
                k = KEY_BITS'(k - (k % BUCKETS) + hot_bucket[$urandom_range(0, HOT_COUNT - 1)]);
            end
            else
                k = KEY_BITS'($urandom);

            if (r.op == CMD_INSERT)
            begin
                seen_keys[seen_wr] = k;
                seen_wr = (seen_wr + 1) % SEEN_DEPTH;
                if (seen_count < SEEN_DEPTH)
                    seen_count++;
            end

            r.k        = k;
            r.typed    = 1'b0;
            r.present  = 1'b0;
            r.overflow = 1'b0;
            send_op(r);
            if (i == RAND_OPS - 1 || i % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain();
            else
                pace();
        end

        repeat (2 * (WAYS + 2)) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
